>>> rtl/soe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soe_pkg: shared types and constants for the set operation engine
// Command and operation codes, default capacity, payload structs.
// ----------------------------------------------------------------------------
package soe_pkg;

   localparam int DefaultCapacity = 16;
   localparam int ValueWidth      = 32;

   localparam logic [1:0] CMD_ADD_MAIN = 2'd0;
   localparam logic [1:0] CMD_QUERY    = 2'd1;
   localparam logic [1:0] CMD_ADD_OPND = 2'd2;
   localparam logic [1:0] CMD_COMPUTE  = 2'd3;

   localparam logic [2:0] OP_UNION  = 3'd0;
   localparam logic [2:0] OP_INTER  = 3'd1;
   localparam logic [2:0] OP_DIFF   = 3'd2;
   localparam logic [2:0] OP_SYMD   = 3'd3;
   localparam logic [2:0] OP_COMPL  = 3'd4;
   localparam logic [2:0] OP_SUBSET = 3'd5;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] elem;
      logic               answer;
      logic               empty_res;
      logic               overflow;
      logic               last;
   } rsp_type;

endpackage

>>> rtl/soe_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soe_req_if: request channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface soe_req_if;
   logic             valid;
   logic             ready;
   soe_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/soe_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soe_rsp_if: response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface soe_rsp_if;
   logic             valid;
   logic             ready;
   soe_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/set_operation_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_operation_engine_core: union, intersection, difference, symmetric difference, complement and subset engine
// Main and operand sets in two synchronous memories, scanned element by
// element through a shared compare loop; results streamed out.
// ----------------------------------------------------------------------------
// Query scans the main set entry by entry. Compute fetches each outer element,
//   compares it against the inner list, then streams out the result words.
// Throughput: one command in flight; the next word is taken once the result
//   is staged in the output register, which holds it until the sink takes it.
// Reset: synchronous, clears counts, mode and control; memories unset.
// ----------------------------------------------------------------------------
module set_operation_engine_core #(
   parameter int SetCapacity = soe_pkg::DefaultCapacity
) (
   input  logic        clock,
   input  logic        reset,
   soe_req_if.sink     req,
   soe_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_wdata
);
   localparam int AW = (SetCapacity > 1) ? $clog2(SetCapacity) : 1;
   localparam int CW = $clog2(SetCapacity + 1);
   // result list may hold main + operand elements
   localparam int RD = 2 * SetCapacity;
   localparam int RW = $clog2(RD + 1);
   localparam int RA = $clog2(RD);
   localparam int MaxRes = 32;

   // state codes
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_QUERY  = 4'd1;  // scan main for value
   localparam logic [3:0] ST_OUTER  = 4'd2;  // fetch next outer candidate
   localparam logic [3:0] ST_INNER  = 4'd3;  // compare candidate to list
   localparam logic [3:0] ST_DECIDE = 4'd4;  // capture candidate, start inner scan
   localparam logic [3:0] ST_EMIT   = 4'd5;  // stream result list
   localparam logic [3:0] ST_SINGLE = 4'd6;  // single-word answer
   localparam logic [3:0] ST_WAIT   = 4'd7;  // memory read latency

   // memories: main, operand and a result/work list
   logic [31:0] main_mem [SetCapacity];
   logic [31:0] opnd_mem [SetCapacity];
   logic [31:0] res_mem  [RD];

   logic [CW-1:0] main_cnt_ff, main_cnt_in, opnd_cnt_ff, opnd_cnt_in;
   logic [2:0]    mode_ff, mode_in;
   logic [3:0]    state_ff, state_in, ret_ff, ret_in;
   logic [31:0]   value_ff, value_in;
   logic [31:0]   cand_ff, cand_in;
   logic          found_ff, found_in;
   logic          ok_ff, ok_in;
   // pass: 0 = main list, 1 = operand list, 2 = symd second filter
   logic [1:0]    pass_ff, pass_in;
   logic [RW-1:0] oi_ff, oi_in;     // outer index
   logic [RW-1:0] ii_ff, ii_in;     // inner index
   logic [RW-1:0] n_ff, n_in;       // result length
   logic [RW-1:0] base_ff, base_in; // symd: start of final list
   logic          rsp_valid_ff, rsp_valid_in;
   soe_pkg::rsp_type rsp_ff, rsp_in;
   // single-word answer staged apart from the output register
   soe_pkg::rsp_type word_ff, word_in;

   // memory read ports
   logic [AW-1:0] m_ra, o_ra;
   logic [RA-1:0] r_ra;
   logic [31:0]   m_rd_ff, o_rd_ff, r_rd_ff;
   logic          m_we, o_we, r_we;
   logic [AW-1:0] m_wa, o_wa;
   logic [RA-1:0] r_wa;
   logic [31:0]   r_wd;

   always_ff @(posedge clock) begin
      if (m_we) main_mem[m_wa] <= value_in;
      if (o_we) opnd_mem[o_wa] <= value_in;
      if (r_we) res_mem[r_wa]  <= r_wd;
      m_rd_ff <= main_mem[m_ra];
      o_rd_ff <= opnd_mem[o_ra];
      r_rd_ff <= res_mem[r_ra];
   end

   wire out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // Candidate outer source and inner compare list per mode and pass.
   // Outer list lengths
   logic [RW-1:0] outer_len;
   logic [RW-1:0] inner_len;
   logic [1:0]    inner_src; // 0 main, 1 operand, 2 result list
   logic          outer_is_res;
   logic          outer_from_opnd;

   always_comb begin
      outer_len       = RW'(main_cnt_ff);
      inner_len       = RW'(opnd_cnt_ff);
      inner_src       = 2'd1;
      outer_is_res    = 1'b0;
      outer_from_opnd = 1'b0;
      case (mode_ff)
         soe_pkg::OP_UNION, soe_pkg::OP_SYMD: begin
            if (pass_ff == 2'd0) begin
               // copy main unconditionally: empty compare list
               inner_len = '0;
            end else if (pass_ff == 2'd1) begin
               outer_len       = RW'(opnd_cnt_ff);
               outer_from_opnd = 1'b1;
               inner_src       = 2'd2;
               inner_len       = n_ff;
            end else begin
               // symd: filter union by intersection (in main and operand)
               outer_len    = base_ff;
               outer_is_res = 1'b1;
               inner_src    = 2'd1;
               inner_len    = RW'(opnd_cnt_ff);
            end
         end
         soe_pkg::OP_COMPL: begin
            outer_len       = RW'(opnd_cnt_ff);
            outer_from_opnd = 1'b1;
            inner_src       = 2'd0;
            inner_len       = RW'(main_cnt_ff);
         end
         default: ;
      endcase
   end

   // symd third pass: reject if in operand AND in main. Two sub-scans
   // are folded by checking operand first then main (found_ff tracks both).
   logic sub_ff, sub_in; // symd: 0 scanning operand, 1 scanning main

   always_comb begin
      main_cnt_in  = main_cnt_ff;
      opnd_cnt_in  = opnd_cnt_ff;
      mode_in      = csr_we ? csr_wdata : mode_ff;
      state_in     = state_ff;
      ret_in       = ret_ff;
      value_in     = value_ff;
      cand_in      = cand_ff;
      found_in     = found_ff;
      ok_in        = ok_ff;
      pass_in      = pass_ff;
      oi_in        = oi_ff;
      ii_in        = ii_ff;
      n_in         = n_ff;
      base_in      = base_ff;
      sub_in       = sub_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in       = rsp_ff;
      word_in      = word_ff;
      m_we = 1'b0; o_we = 1'b0; r_we = 1'b0;
      m_wa = main_cnt_ff[AW-1:0];
      o_wa = opnd_cnt_ff[AW-1:0];
      r_wa = n_ff[RA-1:0];
      r_wd = cand_ff;
      m_ra = ii_ff[AW-1:0];
      o_ra = ii_ff[AW-1:0];
      r_ra = ii_ff[RA-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               value_in = req.data.value;
               word_in  = '0;
               case (req.data.cmd)
                  soe_pkg::CMD_ADD_MAIN: begin
                     if (main_cnt_ff < CW'(SetCapacity)) begin
                        m_we = 1'b1;
                        main_cnt_in = main_cnt_ff + 1'b1;
                     end else word_in.overflow = 1'b1;
                     state_in = ST_SINGLE;
                  end
                  soe_pkg::CMD_ADD_OPND: begin
                     if (opnd_cnt_ff < CW'(SetCapacity)) begin
                        o_we = 1'b1;
                        opnd_cnt_in = opnd_cnt_ff + 1'b1;
                     end else word_in.overflow = 1'b1;
                     state_in = ST_SINGLE;
                  end
                  soe_pkg::CMD_QUERY: begin
                     ii_in    = '0;
                     found_in = 1'b0;
                     m_ra     = '0;
                     state_in = ST_QUERY;
                  end
                  default: begin
                     oi_in   = '0;
                     n_in    = '0;
                     pass_in = '0;
                     ok_in   = 1'b1;
                     state_in = ST_OUTER;
                  end
               endcase
            end
         end

         ST_QUERY: begin
            // m_rd_ff holds entry ii_ff (read issued previous cycle)
            if (ii_ff >= RW'(main_cnt_ff)) begin
               word_in.answer = found_ff;
               state_in = ST_SINGLE;
            end else begin
               if (m_rd_ff == value_ff) found_in = 1'b1;
               ii_in = ii_ff + 1'b1;
               m_ra  = AW'(ii_ff + 1'b1);
               ret_in = ST_QUERY;
               state_in = ST_WAIT;
            end
         end

         ST_WAIT: begin
            // re-present read address so data lands next cycle
            state_in = ret_ff;
         end

         ST_OUTER: begin
            if (mode_ff > soe_pkg::OP_SUBSET) begin
               n_in = '0;
               state_in = ST_EMIT;
            end else if (oi_ff >= outer_len) begin
               // end of this pass
               if ((mode_ff == soe_pkg::OP_UNION || mode_ff == soe_pkg::OP_SYMD)
                   && pass_ff == 2'd0) begin
                  pass_in = 2'd1; oi_in = '0;
               end else if (mode_ff == soe_pkg::OP_SYMD && pass_ff == 2'd1) begin
                  pass_in = 2'd2; oi_in = '0; base_in = n_ff; n_in = n_ff;
               end else if (mode_ff == soe_pkg::OP_SUBSET) begin
                  word_in.answer = ok_ff;
                  opnd_cnt_in = '0;
                  state_in = ST_SINGLE;
               end else begin
                  ii_in = (mode_ff == soe_pkg::OP_SYMD) ? base_ff : '0;
                  r_ra  = (mode_ff == soe_pkg::OP_SYMD) ? base_ff[RA-1:0] : '0;
                  opnd_cnt_in = '0;
                  ret_in = ST_EMIT;
                  state_in = ST_WAIT;
               end
            end else begin
               // fetch outer element oi_ff; the wait cycle re-presents it
               m_ra = oi_ff[AW-1:0];
               o_ra = oi_ff[AW-1:0];
               r_ra = oi_ff[RA-1:0];
               ii_in = oi_ff;
               sub_in = 1'b0;
               found_in = 1'b0;
               ret_in = ST_DECIDE; // DECIDE latches candidate first
               state_in = ST_WAIT;
            end
         end

         ST_DECIDE: begin
            // first visit after fetch: capture candidate, start inner scan
            cand_in = outer_is_res ? r_rd_ff : (outer_from_opnd ? o_rd_ff : m_rd_ff);
            ii_in = '0;
            m_ra = '0; o_ra = '0; r_ra = '0;
            ret_in = ST_INNER;
            state_in = ST_WAIT;
         end

         ST_INNER: begin
            if (ii_ff >= ((pass_ff == 2'd2 && sub_ff) ? RW'(main_cnt_ff) : inner_len)
                || found_ff) begin
               if (pass_ff == 2'd2 && !sub_ff && found_ff) begin
                  // in operand: now check main
                  sub_in = 1'b1; found_in = 1'b0; ii_in = '0; m_ra = '0;
                  ret_in = ST_INNER; state_in = ST_WAIT;
               end else begin
                  logic keep;
                  keep = 1'b0;
                  if (mode_ff == soe_pkg::OP_SUBSET) begin
                     if (!found_ff) ok_in = 1'b0;
                  end else if (pass_ff == 2'd2) begin
                     keep = !(sub_ff && found_ff);
                  end else if ((mode_ff == soe_pkg::OP_UNION ||
                                mode_ff == soe_pkg::OP_SYMD) && pass_ff == 2'd0) begin
                     keep = 1'b1;
                  end else if (mode_ff == soe_pkg::OP_INTER) begin
                     keep = found_ff;
                  end else begin
                     keep = !found_ff;
                  end
                  if (keep) begin
                     r_we = 1'b1; r_wa = n_ff[RA-1:0]; r_wd = cand_ff;
                     n_in = n_ff + 1'b1;
                  end
                  oi_in = oi_ff + 1'b1;
                  state_in = ST_OUTER;
               end
            end else begin
               logic [31:0] d;
               logic [1:0]  src;
               src = (pass_ff == 2'd2) ? (sub_ff ? 2'd0 : 2'd1) : inner_src;
               case (src)
                  2'd0:    d = m_rd_ff;
                  2'd1:    d = o_rd_ff;
                  default: d = r_rd_ff;
               endcase
               if (d == cand_ff) found_in = 1'b1;
               ii_in = ii_ff + 1'b1;
               m_ra = AW'(ii_ff + 1'b1);
               o_ra = AW'(ii_ff + 1'b1);
               r_ra = RA'(ii_ff + 1'b1);
               ret_in = ST_INNER;
               state_in = ST_WAIT;
            end
         end

         ST_EMIT: begin
            // r_rd_ff holds entry ii_ff; final list is [base, n) for symd, else [0, n)
            if (out_free) begin
               logic [RW-1:0] cnt, lim;
               cnt = n_ff - ((mode_ff == soe_pkg::OP_SYMD) ? base_ff : '0);
               lim = (cnt > RW'(MaxRes)) ? RW'(MaxRes) : cnt;
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               if (mode_ff > soe_pkg::OP_SUBSET) opnd_cnt_in = '0;
               if (lim == '0) begin
                  rsp_in.empty_res = 1'b1;
                  rsp_in.last = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  logic [RW-1:0] pos;
                  pos = ii_ff - ((mode_ff == soe_pkg::OP_SYMD) ? base_ff : '0);
                  rsp_in.elem = r_rd_ff;
                  if (pos + 1'b1 == lim) begin
                     rsp_in.last = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     ii_in = ii_ff + 1'b1;
                     r_ra  = RA'(ii_ff + 1'b1);
                     ret_in = ST_EMIT;
                     state_in = ST_WAIT;
                  end
               end
            end
         end

         ST_SINGLE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = word_ff;
               rsp_in.last = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_cnt_ff  <= '0;
         opnd_cnt_ff  <= '0;
         mode_ff      <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         main_cnt_ff  <= main_cnt_in;
         opnd_cnt_ff  <= opnd_cnt_in;
         mode_ff      <= mode_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ret_ff   <= ret_in;
      value_ff <= value_in;
      cand_ff  <= cand_in;
      found_ff <= found_in;
      ok_ff    <= ok_in;
      pass_ff  <= pass_in;
      oi_ff    <= oi_in;
      ii_ff    <= ii_in;
      n_ff     <= n_in;
      base_ff  <= base_in;
      sub_ff   <= sub_in;
      rsp_ff   <= rsp_in;
      word_ff  <= word_in;
   end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for set_operation_engine_core
// Drives add, query and compute words through the request channel, predicts
// every result word from a model of both sets, and checks the result channel
// field by field. The mode register is rewritten between phases while idle.
// ----------------------------------------------------------------------------

class set_scoreboard;
   logic signed [31:0]  main_set[$];
   logic signed [31:0]  opnd_set[$];
   logic [2:0]          mode;
   soe_pkg::rsp_type    pending[$];
   int                  errors;
   int                  checked;
   int                  n_empty, n_ovf, n_long;

   function new();
      mode = soe_pkg::OP_UNION;
   endfunction

   function bit has(ref logic signed [31:0] q[$], input logic signed [31:0] v);
      foreach (q[i]) if (q[i] == v) return 1;
      return 0;
   endfunction

   function void push_word(logic signed [31:0] e, bit a, bit em, bit ov, bit l);
      soe_pkg::rsp_type r;
      r.elem = e; r.answer = a; r.empty_res = em; r.overflow = ov; r.last = l;
      pending.insert(pending.size(), r);
   endfunction

   function void note(soe_pkg::req_type w);
      logic signed [31:0] res[$];
      logic signed [31:0] uni[$];
      logic signed [31:0] itr[$];
      bit ok;
      int n;
      if (w.cmd == soe_pkg::CMD_ADD_MAIN || w.cmd == soe_pkg::CMD_ADD_OPND) begin
         if (w.cmd == soe_pkg::CMD_ADD_MAIN) begin
            ok = main_set.size() < soe_pkg::DefaultCapacity;
            if (ok) main_set.insert(main_set.size(), w.value);
         end else begin
            ok = opnd_set.size() < soe_pkg::DefaultCapacity;
            if (ok) opnd_set.insert(opnd_set.size(), w.value);
         end
         if (!ok) n_ovf++;
         push_word(0, 0, 0, !ok, 1);
         return;
      end
      if (w.cmd == soe_pkg::CMD_QUERY) begin
         push_word(0, has(main_set, w.value), 0, 0, 1);
         return;
      end
      foreach (main_set[i]) uni.insert(uni.size(), main_set[i]);
      foreach (opnd_set[i])
         if (!has(uni, opnd_set[i])) uni.insert(uni.size(), opnd_set[i]);
      foreach (main_set[i])
         if (has(opnd_set, main_set[i])) itr.insert(itr.size(), main_set[i]);
      case (mode)
         soe_pkg::OP_UNION: res = uni;
         soe_pkg::OP_INTER: res = itr;
         soe_pkg::OP_DIFF:
            foreach (main_set[i]) if (!has(opnd_set, main_set[i]))
               res.insert(res.size(), main_set[i]);
         soe_pkg::OP_SYMD:
            foreach (uni[i]) if (!has(itr, uni[i])) res.insert(res.size(), uni[i]);
         soe_pkg::OP_COMPL:
            foreach (opnd_set[i]) if (!has(main_set, opnd_set[i]))
               res.insert(res.size(), opnd_set[i]);
         soe_pkg::OP_SUBSET: begin
            ok = 1;
            foreach (main_set[i]) if (!has(opnd_set, main_set[i])) ok = 0;
            opnd_set.delete();
            push_word(0, ok, 0, 0, 1);
            return;
         end
         default: ;
      endcase
      opnd_set.delete();
      if (res.size() == 0) begin
         n_empty++;
         push_word(0, 0, 1, 0, 1);
         return;
      end
      n = res.size() > 32 ? 32 : res.size();
      if (n > 16) n_long++;
      for (int k = 0; k < n; k++) push_word(res[k], 0, 0, 0, k == n - 1);
   endfunction

   function void check(soe_pkg::rsp_type got);
      soe_pkg::rsp_type exp;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected result word %h", got);
         return;
      end
      exp = pending.pop_front();
      checked++;
      if (got !== exp) begin
         errors++;
         if (errors <= 10) begin
            $display("mismatch: exp elem %0d ans %b emp %b ovf %b last %b",
                     exp.elem, exp.answer, exp.empty_res, exp.overflow, exp.last);
            $display("          got elem %0d ans %b emp %b ovf %b last %b",
                     got.elem, got.answer, got.empty_res, got.overflow, got.last);
         end
      end
   endfunction
endclass

module tb;
   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [2:0] csr_wdata = '0;
   soe_req_if req();
   soe_rsp_if rsp();
   set_scoreboard sb;
   longint cycles = 0;
   bit hold_rsp = 0;
   int sent = 0;
   logic signed [31:0] pool[8];

   set_operation_engine_core u_dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   initial begin
      req.valid = 0;
      req.data = '0;
      rsp.ready = 0;
   end

   // watchdog: slowest run is well under this
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("tb failed");
         $finish;
      end
   end

   // result side: sample at rising edge, ready changes on falling edge
   always @(posedge clock)
      if (!reset && rsp.valid && rsp.ready) sb.check(rsp.data);

   function int gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
   endfunction

   initial begin
      int g;
      @(negedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp.ready <= 0;
            @(negedge clock);
         end else begin
            g = ($urandom_range(0, 3) == 0) ? gap() : 0;
            if (g > 0) begin
               rsp.ready <= 0;
               repeat (g) @(negedge clock);
            end
            rsp.ready <= 1;
            @(negedge clock);
         end
      end
   end

   // valid stays up after an accept so words can follow back to back
   task automatic send(logic [1:0] c, logic signed [31:0] v);
      soe_pkg::req_type w;
      w.cmd = c; w.value = v;
      req.valid <= 1;
      req.data <= w;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note(w);
      sent++;
      @(negedge clock);
   endtask

   task automatic pause(int n);
      req.valid <= 0;
      repeat (n) @(negedge clock);
   endtask

   task automatic send_gap(logic [1:0] c, logic signed [31:0] v);
      int g;
      send(c, v);
      if ($urandom_range(0, 2) == 0) begin
         g = gap();
         if (g > 0) pause(g);
      end
   endtask

   task automatic drain();
      req.valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_mode(logic [2:0] m);
      drain();
      csr_we <= 1;
      csr_wdata <= m;
      @(negedge clock);
      csr_we <= 0;
      sb.mode = m;
   endtask

   function logic signed [31:0] pick();
      case ($urandom_range(0, 3))
         0: return pool[$urandom_range(0, 7)];
         1: return 32'sh7fffffff ^ {31'd0, 1'($urandom_range(0, 1))};
         2: return 32'sh80000000 | $urandom_range(0, 1);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      sb = new();
      foreach (pool[i]) pool[i] = $urandom;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: extremes, every command, empty and subset cases
      send(soe_pkg::CMD_COMPUTE, 0);                 // empty union
      send(soe_pkg::CMD_QUERY, 32'sh80000000);       // query empty set
      send(soe_pkg::CMD_ADD_MAIN, 32'sh80000000);
      send(soe_pkg::CMD_ADD_MAIN, 32'sh7fffffff);
      send(soe_pkg::CMD_ADD_MAIN, 32'sh7fffffff);    // duplicate kept
      send(soe_pkg::CMD_ADD_OPND, -1);
      send(soe_pkg::CMD_ADD_OPND, 32'sh7fffffff);
      send(soe_pkg::CMD_QUERY, 32'sh7fffffff);
      send(soe_pkg::CMD_QUERY, 0);
      send(soe_pkg::CMD_COMPUTE, 0);
      for (int m = 1; m <= 7; m++) begin
         set_mode(m[2:0]);
         send(soe_pkg::CMD_ADD_OPND, 32'sh80000000);
         send(soe_pkg::CMD_ADD_OPND, -1);
         send(soe_pkg::CMD_COMPUTE, $urandom);
      end
      set_mode(soe_pkg::OP_SUBSET);
      send(soe_pkg::CMD_COMPUTE, 0);                 // main not within empty operand

      // fill both stores past capacity, long union
      set_mode(soe_pkg::OP_UNION);
      for (int i = 0; i < 14; i++) send(soe_pkg::CMD_ADD_MAIN, $urandom);
      for (int i = 0; i < 18; i++) send(soe_pkg::CMD_ADD_OPND, $urandom);
      // receiver holds off while the sender keeps offering
      fork
         begin
            hold_rsp = 1;
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end
         begin
            send(soe_pkg::CMD_COMPUTE, 0);
            send(soe_pkg::CMD_QUERY, 32'sh7fffffff);
            send(soe_pkg::CMD_ADD_MAIN, 1);
         end
      join
      drain();

      // random phases; main store is full so main adds overflow, subsets still vary
      for (int ph = 0; ph < 8; ph++) begin
         set_mode(ph < 6 ? ph[2:0] : 3'($urandom_range(0, 7)));
         repeat ($urandom_range(3, 10)) begin
            if ($urandom_range(0, 1))
               send_gap(soe_pkg::CMD_ADD_OPND, sb.main_set[$urandom_range(0, 15)]);
            else send_gap(soe_pkg::CMD_ADD_OPND, pick());
         end
         send_gap(soe_pkg::CMD_QUERY,
                  $urandom_range(0, 1) ? sb.main_set[$urandom_range(0, 15)] : pick());
         send_gap(soe_pkg::CMD_ADD_MAIN, pick());
         send_gap(soe_pkg::CMD_COMPUTE, $urandom);
      end
      drain();    // sender pauses until everything has come back
      for (int i = 0; i < 20; i++) begin
         if ($urandom_range(0, 4) == 0) set_mode(3'($urandom_range(0, 7)));
         send_gap(2'($urandom_range(1, 3)), pick());
      end
      drain();

      $display("sent %0d request words, checked %0d result words", sent, sb.checked);
      $display("empty results %0d, dropped adds %0d, long results %0d",
               sb.n_empty, sb.n_ovf, sb.n_long);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end
endmodule
